/* src/smeu_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared constants, command and error codes, and the ALU request type.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int STACK_DEPTH_DEF  = 256;
    localparam int LOCAL_SLOTS_DEF  = 256;
    localparam int GLOBAL_SLOTS_DEF = 256;

    localparam int DATA_W      = 64;
    localparam int CMD_W       = 5;
    localparam int VIDX_W      = 9;
    localparam int DEPTH_OUT_W = 9;
    localparam int ERR_W       = 3;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 5'd0,
        CMD_ADD    = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_MUL    = 5'd3,
        CMD_DIV    = 5'd4,
        CMD_MOD    = 5'd5,
        CMD_LT     = 5'd6,
        CMD_LE     = 5'd7,
        CMD_GT     = 5'd8,
        CMD_GE     = 5'd9,
        CMD_EQ     = 5'd10,
        CMD_NE     = 5'd11,
        CMD_SHL    = 5'd12,
        CMD_SHR    = 5'd13,
        CMD_OR     = 5'd14,
        CMD_AND    = 5'd15,
        CMD_XOR    = 5'd16,
        CMD_INVERT = 5'd17,
        CMD_NOT    = 5'd18,
        CMD_NEGATE = 5'd19,
        CMD_DROP   = 5'd20,
        CMD_LOAD   = 5'd21,
        CMD_ASSIGN = 5'd22,
        CMD_INC    = 5'd23,
        CMD_DEC    = 5'd24,
        CMD_JT     = 5'd25,
        CMD_JF     = 5'd26
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_UNDERFLOW = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_DIV_ZERO  = 3'd3,
        ERR_BAD_CMD   = 3'd4
    } err_t;

    typedef enum logic [4:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD,
        ALU_LT, ALU_LE, ALU_GT, ALU_GE, ALU_EQ, ALU_NE,
        ALU_SHL, ALU_SHR, ALU_OR, ALU_AND, ALU_XOR,
        ALU_LNOT, ALU_BNOT, ALU_NEG, ALU_INC, ALU_DEC
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

/* src/smeu_alu.sv */
// ----------------------------------------------------------------------------
// Stack machine ALU
// One shared 64-bit adder serves add, subtract, compare, negate and inc/dec,
// and is reused bit by bit for shift-add multiply and restoring signed divide.
// ----------------------------------------------------------------------------
module smeu_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smeu_pkg::alu_req_t            req,
    input  logic [smeu_pkg::DATA_W-1:0]   a,
    input  logic [smeu_pkg::DATA_W-1:0]   b,
    output logic                          done,
    output logic [smeu_pkg::DATA_W-1:0]   result
);

    localparam int DW = smeu_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [1:0] {PH_IDLE, PH_ITER, PH_FIX} phase_t;

    phase_t              phase_reg;
    smeu_pkg::alu_op_t   op_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DW-1:0]       acc_reg;
    logic [DW-1:0]       aux_reg;
    logic [DW-1:0]       sh_reg;
    logic                neg_reg;
    logic                done_reg;
    logic [DW-1:0]       result_reg;

    logic [DW-1:0]       add_x;
    logic [DW-1:0]       add_y;
    logic                add_cin;
    logic [DW:0]         sum;
    logic [DW-1:0]       rem_shift;
    logic [DW-1:0]       fix_val;
    logic [DW-1:0]       mag_a;
    logic [DW-1:0]       mag_b;
    logic                lt;
    logic                eq;
    logic [DW-1:0]       single;

    assign rem_shift = {acc_reg[DW-2:0], sh_reg[DW-1]};
    assign fix_val   = (op_reg == smeu_pkg::ALU_DIV) ? sh_reg : acc_reg;
    assign mag_a     = a[DW-1] ? (~a + DW'(1)) : a;
    assign mag_b     = b[DW-1] ? (~b + DW'(1)) : b;

    // Operand selection for the shared adder.
    always_comb
    begin
        add_x   = a;
        add_y   = b;
        add_cin = 1'b0;
        unique case (phase_reg)
            PH_ITER:
            begin
                if (op_reg == smeu_pkg::ALU_MUL)
                begin
                    add_x = acc_reg;
                    add_y = aux_reg;
                end
                else
                begin
                    add_x   = rem_shift;
                    add_y   = ~aux_reg;
                    add_cin = 1'b1;
                end
            end
            PH_FIX:
            begin
                add_x   = '0;
                add_y   = ~fix_val;
                add_cin = 1'b1;
            end
            default:
            begin
                case (req.op)
                    smeu_pkg::ALU_SUB, smeu_pkg::ALU_LT, smeu_pkg::ALU_LE,
                    smeu_pkg::ALU_GT, smeu_pkg::ALU_GE:
                    begin
                        add_y   = ~b;
                        add_cin = 1'b1;
                    end
                    smeu_pkg::ALU_NEG:
                    begin
                        add_x   = '0;
                        add_y   = ~a;
                        add_cin = 1'b1;
                    end
                    smeu_pkg::ALU_INC:
                    begin
                        add_y   = '0;
                        add_cin = 1'b1;
                    end
                    smeu_pkg::ALU_DEC:
                    begin
                        add_y = '1;
                    end
                    default:
                    begin
                        add_y = b;
                    end
                endcase
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + (DW+1)'(add_cin);

    // Signed less-than from the subtract: when signs differ, a is smaller if negative.
    assign lt = (a[DW-1] != b[DW-1]) ? a[DW-1] : sum[DW-1];
    assign eq = (a == b);

    always_comb
    begin
        case (req.op)
            smeu_pkg::ALU_LT:   single = {{(DW-1){1'b0}}, lt};
            smeu_pkg::ALU_LE:   single = {{(DW-1){1'b0}}, lt | eq};
            smeu_pkg::ALU_GT:   single = {{(DW-1){1'b0}}, ~lt & ~eq};
            smeu_pkg::ALU_GE:   single = {{(DW-1){1'b0}}, ~lt};
            smeu_pkg::ALU_EQ:   single = {{(DW-1){1'b0}}, eq};
            smeu_pkg::ALU_NE:   single = {{(DW-1){1'b0}}, ~eq};
            smeu_pkg::ALU_SHL:  single = a << b[CNT_W-1:0];
            smeu_pkg::ALU_SHR:  single = DW'($signed(a) >>> b[CNT_W-1:0]);
            smeu_pkg::ALU_OR:   single = a | b;
            smeu_pkg::ALU_AND:  single = a & b;
            smeu_pkg::ALU_XOR:  single = a ^ b;
            smeu_pkg::ALU_LNOT: single = {{(DW-1){1'b0}}, a == '0};
            smeu_pkg::ALU_BNOT: single = ~a;
            default:            single = sum[DW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            op_reg     <= smeu_pkg::ALU_ADD;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            aux_reg    <= '0;
            sh_reg     <= '0;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        if (req.op == smeu_pkg::ALU_MUL)
                        begin
                            aux_reg   <= a;
                            sh_reg    <= b;
                            neg_reg   <= 1'b0;
                            phase_reg <= PH_ITER;
                        end
                        else if (req.op == smeu_pkg::ALU_DIV || req.op == smeu_pkg::ALU_MOD)
                        begin
                            aux_reg   <= mag_b;
                            sh_reg    <= mag_a;
                            neg_reg   <= (req.op == smeu_pkg::ALU_MOD) ? a[DW-1]
                                                                        : (a[DW-1] ^ b[DW-1]);
                            phase_reg <= PH_ITER;
                        end
                        else
                        begin
                            result_reg <= single;
                            done_reg   <= 1'b1;
                        end
                    end
                end
                PH_ITER:
                begin
                    if (op_reg == smeu_pkg::ALU_MUL)
                    begin
                        if (sh_reg[0])
                        begin
                            acc_reg <= sum[DW-1:0];
                        end
                        aux_reg <= aux_reg << 1;
                        sh_reg  <= sh_reg >> 1;
                    end
                    else
                    begin
                        // Carry out means no borrow: the divisor fits, quotient bit is one.
                        acc_reg <= sum[DW] ? sum[DW-1:0] : rem_shift;
                        sh_reg  <= {sh_reg[DW-2:0], sum[DW]};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DW-1))
                    begin
                        phase_reg <= PH_FIX;
                    end
                end
                default:
                begin
                    result_reg <= neg_reg ? sum[DW-1:0] : fix_val;
                    done_reg   <= 1'b1;
                    phase_reg  <= PH_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/stack_machine_execute_unit.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one decoded bytecode operation per transaction on a 64-bit
// operand stack and a local/global variable store.
// ----------------------------------------------------------------------------
// After reset the unit first zeroes its variable store, one slot per cycle,
// and s_tready stays low meanwhile. It then works on one transaction at a
// time. Push, load, drop, assign, the branch tests, and every error case
// are settled in the execute state; the simple arithmetic, compare, shift
// and logic commands and inc/dec pass through the shared ALU; mul, div and
// mod run the 64 single-bit iterations of that ALU's one adder plus a
// sign-fix step. The next transaction is accepted in the cycle after the
// result is loaded into the output register, even if that result has not
// yet been taken.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH  = smeu_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_SLOTS  = smeu_pkg::LOCAL_SLOTS_DEF,
    parameter int GLOBAL_SLOTS = smeu_pkg::GLOBAL_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // command[4:0], immediate[68:5], var_index[77:69], zero pad[79:78]
    input  logic [smeu_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // top_value[63:0], depth[72:64], branch_taken[73], error_code[76:74], zero pad[79:77]
    output logic [smeu_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int DATW        = smeu_pkg::DATA_W;
    localparam int SW          = $clog2(STACK_DEPTH);
    localparam int DW          = $clog2(STACK_DEPTH + 1);
    localparam int STORE_SLOTS = LOCAL_SLOTS + GLOBAL_SLOTS;
    localparam int VW          = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
    localparam int CW          = $clog2(STORE_SLOTS + 1);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_WAIT, ST_FINISH} state_t;

    // Input fields.
    logic [smeu_pkg::CMD_W-1:0]  in_cmd;
    logic [DATW-1:0]             in_imm;
    logic [smeu_pkg::VIDX_W-1:0] in_idx;

    assign in_cmd = s_tdata[4:0];
    assign in_imm = s_tdata[68:5];
    assign in_idx = s_tdata[77:69];

    state_t                 state_reg,    state_next;
    smeu_pkg::cmd_t         cmd_reg,      cmd_next;
    logic [DATW-1:0]        imm_reg,      imm_next;
    logic                   have_reg,     have_next;
    logic [VW-1:0]          pos_reg,      pos_next;
    logic [DW-1:0]          depth_reg,    depth_next;
    logic [DATW-1:0]        tos_reg,      tos_next;
    smeu_pkg::err_t         err_reg,      err_next;
    logic                   taken_reg,    taken_next;
    logic [CW-1:0]          clr_cnt_reg,  clr_cnt_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [smeu_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memories and their ports.
    logic [DATW-1:0] stack_mem [STACK_DEPTH];
    logic [DATW-1:0] var_mem   [STORE_SLOTS];
    logic [SW-1:0]   stk_raddr;
    logic            stk_we;
    logic [SW-1:0]   stk_waddr;
    logic [DATW-1:0] stk_wdata;
    logic [DATW-1:0] nos_rd_reg;
    logic [VW-1:0]   var_raddr;
    logic            var_we;
    logic [VW-1:0]   var_waddr;
    logic [DATW-1:0] var_wdata;
    logic [DATW-1:0] var_rd_reg;

    // Shared ALU.
    smeu_pkg::alu_req_t alu_req;
    logic [DATW-1:0]    alu_a;
    logic               alu_done;
    logic [DATW-1:0]    alu_result;
    logic               is_binary;
    logic               is_var_op;
    logic [DATW-1:0]    push_val;
    logic [DATW-1:0]    top_out;

    // The second entry from the top is always being read, so it is on hand
    // the cycle after a command is accepted.
    assign stk_raddr = SW'(depth_reg - DW'(2));
    assign var_raddr = VW'(in_idx);

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        nos_rd_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[var_waddr] <= var_wdata;
        end
        var_rd_reg <= var_mem[var_raddr];
    end

    assign is_binary = (cmd_reg >= smeu_pkg::CMD_ADD) && (cmd_reg <= smeu_pkg::CMD_XOR);
    assign is_var_op = (cmd_reg == smeu_pkg::CMD_INC) || (cmd_reg == smeu_pkg::CMD_DEC);
    assign alu_a     = is_var_op ? var_rd_reg : (is_binary ? nos_rd_reg : tos_reg);
    assign push_val  = (cmd_reg == smeu_pkg::CMD_PUSH) ? imm_reg
                                                        : (have_reg ? var_rd_reg : '0);
    assign top_out   = (depth_reg != '0) ? tos_reg : '0;

    // Command to ALU operation.
    always_comb
    begin
        alu_req.start = 1'b0;
        unique case (cmd_reg)
            smeu_pkg::CMD_ADD:    alu_req.op = smeu_pkg::ALU_ADD;
            smeu_pkg::CMD_SUB:    alu_req.op = smeu_pkg::ALU_SUB;
            smeu_pkg::CMD_MUL:    alu_req.op = smeu_pkg::ALU_MUL;
            smeu_pkg::CMD_DIV:    alu_req.op = smeu_pkg::ALU_DIV;
            smeu_pkg::CMD_MOD:    alu_req.op = smeu_pkg::ALU_MOD;
            smeu_pkg::CMD_LT:     alu_req.op = smeu_pkg::ALU_LT;
            smeu_pkg::CMD_LE:     alu_req.op = smeu_pkg::ALU_LE;
            smeu_pkg::CMD_GT:     alu_req.op = smeu_pkg::ALU_GT;
            smeu_pkg::CMD_GE:     alu_req.op = smeu_pkg::ALU_GE;
            smeu_pkg::CMD_EQ:     alu_req.op = smeu_pkg::ALU_EQ;
            smeu_pkg::CMD_NE:     alu_req.op = smeu_pkg::ALU_NE;
            smeu_pkg::CMD_SHL:    alu_req.op = smeu_pkg::ALU_SHL;
            smeu_pkg::CMD_SHR:    alu_req.op = smeu_pkg::ALU_SHR;
            smeu_pkg::CMD_OR:     alu_req.op = smeu_pkg::ALU_OR;
            smeu_pkg::CMD_AND:    alu_req.op = smeu_pkg::ALU_AND;
            smeu_pkg::CMD_XOR:    alu_req.op = smeu_pkg::ALU_XOR;
            smeu_pkg::CMD_INVERT: alu_req.op = smeu_pkg::ALU_LNOT;
            smeu_pkg::CMD_NOT:    alu_req.op = smeu_pkg::ALU_BNOT;
            smeu_pkg::CMD_NEGATE: alu_req.op = smeu_pkg::ALU_NEG;
            smeu_pkg::CMD_DEC:    alu_req.op = smeu_pkg::ALU_DEC;
            default:              alu_req.op = smeu_pkg::ALU_INC;
        endcase
        if (state_reg == ST_EXEC)
        begin
            unique case (cmd_reg) inside
                [smeu_pkg::CMD_ADD:smeu_pkg::CMD_XOR]:
                    alu_req.start = (depth_reg >= DW'(2)) &&
                                    !(((cmd_reg == smeu_pkg::CMD_DIV) ||
                                       (cmd_reg == smeu_pkg::CMD_MOD)) && (tos_reg == '0));
                smeu_pkg::CMD_INVERT, smeu_pkg::CMD_NOT, smeu_pkg::CMD_NEGATE:
                    alu_req.start = (depth_reg != '0);
                smeu_pkg::CMD_INC, smeu_pkg::CMD_DEC:
                    alu_req.start = have_reg;
                default:
                    alu_req.start = 1'b0;
            endcase
        end
    end

    smeu_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (tos_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        imm_next      = imm_reg;
        have_next     = have_reg;
        pos_next      = pos_reg;
        depth_next    = depth_reg;
        tos_next      = tos_reg;
        err_next      = err_reg;
        taken_next    = taken_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        stk_we        = 1'b0;
        stk_waddr     = SW'(depth_reg);
        stk_wdata     = alu_result;
        var_we        = 1'b0;
        var_waddr     = pos_reg;
        var_wdata     = alu_result;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                var_we       = 1'b1;
                var_waddr    = VW'(clr_cnt_reg);
                var_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(STORE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next   = smeu_pkg::cmd_t'(in_cmd);
                    imm_next   = in_imm;
                    have_next  = ({23'b0, in_idx} < 32'(STORE_SLOTS));
                    pos_next   = VW'(in_idx);
                    err_next   = smeu_pkg::ERR_OK;
                    taken_next = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                unique case (cmd_reg) inside
                    [smeu_pkg::CMD_ADD:smeu_pkg::CMD_XOR]:
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            err_next = smeu_pkg::ERR_UNDERFLOW;
                        end
                        else if (((cmd_reg == smeu_pkg::CMD_DIV) ||
                                  (cmd_reg == smeu_pkg::CMD_MOD)) && (tos_reg == '0))
                        begin
                            err_next = smeu_pkg::ERR_DIV_ZERO;
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    smeu_pkg::CMD_PUSH, smeu_pkg::CMD_LOAD:
                    begin
                        if (depth_reg >= DW'(STACK_DEPTH))
                        begin
                            err_next = smeu_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            stk_we     = 1'b1;
                            stk_waddr  = SW'(depth_reg);
                            stk_wdata  = push_val;
                            tos_next   = push_val;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    smeu_pkg::CMD_INVERT, smeu_pkg::CMD_NOT, smeu_pkg::CMD_NEGATE:
                    begin
                        if (depth_reg == '0)
                        begin
                            err_next = smeu_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    smeu_pkg::CMD_DROP, smeu_pkg::CMD_ASSIGN,
                    smeu_pkg::CMD_JT, smeu_pkg::CMD_JF:
                    begin
                        if (depth_reg == '0)
                        begin
                            err_next = smeu_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            // Popping exposes the entry that was read below the top.
                            depth_next = depth_reg - DW'(1);
                            tos_next   = nos_rd_reg;
                            var_we     = (cmd_reg == smeu_pkg::CMD_ASSIGN) && have_reg;
                            var_wdata  = tos_reg;
                            if (cmd_reg == smeu_pkg::CMD_JT)
                            begin
                                taken_next = (tos_reg != '0);
                            end
                            else if (cmd_reg == smeu_pkg::CMD_JF)
                            begin
                                taken_next = (tos_reg == '0);
                            end
                        end
                    end
                    smeu_pkg::CMD_INC, smeu_pkg::CMD_DEC:
                    begin
                        // A slot beyond the store leaves everything as it is.
                        if (have_reg)
                        begin
                            state_next = ST_WAIT;
                        end
                    end
                    default:
                    begin
                        err_next = smeu_pkg::ERR_BAD_CMD;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ST_FINISH;
                    if (is_var_op)
                    begin
                        var_we = 1'b1;
                    end
                    else if (is_binary)
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = SW'(depth_reg - DW'(2));
                        tos_next   = alu_result;
                        depth_next = depth_reg - DW'(1);
                    end
                    else
                    begin
                        stk_we    = 1'b1;
                        stk_waddr = SW'(depth_reg - DW'(1));
                        tos_next  = alu_result;
                    end
                end
            end
            default:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, err_reg, taken_reg,
                                     smeu_pkg::DEPTH_OUT_W'(depth_reg), top_out};
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cmd_reg      <= smeu_pkg::CMD_PUSH;
            imm_reg      <= '0;
            have_reg     <= 1'b0;
            pos_reg      <= '0;
            depth_reg    <= '0;
            tos_reg      <= '0;
            err_reg      <= smeu_pkg::ERR_OK;
            taken_reg    <= 1'b0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            imm_reg      <= imm_next;
            have_reg     <= have_next;
            pos_reg      <= pos_next;
            depth_reg    <= depth_next;
            tos_reg      <= tos_next;
            err_reg      <= err_next;
            taken_reg    <= taken_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The stack never holds more entries than it has room for.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // An erroring command leaves the stack depth as it was.
    a_err_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && err_next != smeu_pkg::ERR_OK) |=> $stable(depth_reg))
        else $error("stack depth changed on an error");

    // The ALU reports completion only while the sequencer waits for it.
    a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> state_reg == ST_WAIT)
        else $error("ALU finished outside the wait state");

    // A taken branch is never reported together with an error.
    a_taken_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg |-> err_reg == smeu_pkg::ERR_OK)
        else $error("branch taken with an error");

    // No transaction is accepted during the clearing pass.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready && !m_tvalid_reg)
        else $error("traffic during the clearing pass");

endmodule
